// ===== rtl/sru_pkg.sv =====
package sru_pkg;

    // number of element values covered by the binomial table
    localparam int unsigned MAX_VARIETIES = 32;

    localparam int unsigned RANK_W  = 30;
    localparam int unsigned ELEM_W  = 5;
    localparam int unsigned CARD_W  = 6;
    localparam int unsigned TAB_MAX = 32;

    localparam logic [CARD_W-1:0] CARD_RESET = 6'd2;

    typedef enum logic [1:0] {
        ADDR_RANK  = 2'd0,
        ADDR_LIMIT = 2'd1,
        ADDR_SCAN  = 2'd2
    } t_addr_sel;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_R_FETCH = 9'b000000010,
        S_R_ADD   = 9'b000000100,
        S_R_EMIT  = 9'b000001000,
        S_U_LIMIT = 9'b000010000,
        S_U_CHECK = 9'b000100000,
        S_U_ERR   = 9'b001000000,
        S_U_FETCH = 9'b010000000,
        S_U_TEST  = 9'b100000000
    } t_state;

    typedef struct packed {
        logic      capture;
        logic      rank_acc;
        logic      rank_emit;
        logic      scan_init;
        logic      scan_step;
        logic      elem_emit;
        logic      err_emit;
        t_addr_sel addr_sel;
    } t_cmd;

    typedef struct packed {
        logic rank_done;
        logic in_range;
        logic found;
        logic last_elem;
        logic slot_free;
    } t_sts;

    // elaboration-time binomial coefficient by pascal's rule, zero when j > n
    function automatic longint unsigned choose(int unsigned n, int unsigned j);
        longint unsigned row [0:TAB_MAX];
        if ((j > n) || (n > TAB_MAX)) begin
            return 0;
        end
        for (int unsigned m = 0; m <= TAB_MAX; m++) begin
            row[m] = 0;
        end
        row[0] = 1;
        for (int unsigned m = 1; m <= n; m++) begin
            for (int unsigned c = m; c > 0; c--) begin
                row[c] = row[c] + row[c-1];
            end
        end
        return row[j];
    endfunction

endpackage

// ===== rtl/subset_rank_unrank_unit.sv =====
// colex rank / unrank of k-subsets by the combinatorial number system
//
// input channel (i_in_valid / o_in_stall): one beat is either a subset
// element (i_mode 0) or a rank to expand (i_mode 1). output channel
// (o_out_valid / i_out_stall): rank results, subset elements largest
// position first with o_last on position 0, or a single error beat when
// the rank is at or above C(32, card).
// config channel (i_cfg_valid / o_cfg_ready): writes card, always ready;
// the user must write it only while idle; the block does not enforce it.
//
// sequencing: a rank-mode beat passes the accept, fetch and add steps, and
// an emit step when it closes the subset and emits the rank. an unrank beat
// passes the accept step, then the limit read and check of the range check,
// and an emit step for an error beat; otherwise it walks candidate values
// from 31 down to 0, each a binomial rom read step and a compare step that
// also sends the element when it fits.
// the registered binomial rom read sets the separate read and compare steps.
// one item is in flight at a time; o_in_stall is high while busy.
//
// reset clears the controller, the running rank sum and element count,
// the output valid and sets card to 2. a stalled output beat holds its
// payload; the controller waits in its emit step until the slot frees.
module subset_rank_unrank_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [sru_pkg::ELEM_W-1:0]    i_element,
    input  logic [sru_pkg::RANK_W-1:0]    i_rank_in,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_kind,
    output logic [sru_pkg::RANK_W-1:0]    o_rank_out,
    output logic [sru_pkg::ELEM_W-1:0]    o_element_out,
    output logic [sru_pkg::ELEM_W-1:0]    o_position,
    output logic                          o_last,
    output logic                          o_error,
    // card register write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sru_pkg::CARD_W-1:0]    i_cfg_data
);

    sru_pkg::t_cmd w_cmd;
    sru_pkg::t_sts w_sts;

    // card writes go straight into a register, nothing to hold off
    assign o_cfg_ready = 1'b1;

    sru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // sum, count, scan registers, rom and the output beat register
    sru_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_element     (i_element),
        .i_rank_in     (i_rank_in),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_rank_out    (o_rank_out),
        .o_element_out (o_element_out),
        .o_position    (o_position),
        .o_last        (o_last),
        .o_error       (o_error)
    );

endmodule

// ===== rtl/sru_binom_rom.sv =====
module sru_binom_rom (
    input  logic                          i_clk,
    input  logic [sru_pkg::CARD_W-1:0]    i_n,
    input  logic [sru_pkg::CARD_W-1:0]    i_j,
    output logic [sru_pkg::RANK_W-1:0]    o_data
);

    logic [sru_pkg::RANK_W-1:0] w_tab [0:sru_pkg::TAB_MAX][0:sru_pkg::TAB_MAX];
    logic [sru_pkg::RANK_W-1:0] r_data;

    for (genvar gn = 0; gn <= sru_pkg::TAB_MAX; gn++) begin : g_row
        for (genvar gj = 0; gj <= sru_pkg::TAB_MAX; gj++) begin : g_col
            assign w_tab[gn][gj] = sru_pkg::RANK_W'(sru_pkg::choose(gn, gj));
        end
    end

    // registered read, out-of-table indexes read as zero
    always_ff @(posedge i_clk) begin
        if ((i_n > sru_pkg::CARD_W'(sru_pkg::TAB_MAX)) ||
            (i_j > sru_pkg::CARD_W'(sru_pkg::TAB_MAX))) begin
            r_data <= '0;
        end else begin
            r_data <= w_tab[i_n][i_j];
        end
    end

    assign o_data = r_data;

endmodule

// ===== rtl/sru_datapath.sv =====
module sru_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sru_pkg::t_cmd                 i_cmd,
    output sru_pkg::t_sts                 o_sts,
    input  logic                          i_cfg_we,
    input  logic [sru_pkg::CARD_W-1:0]    i_cfg_data,
    input  logic [sru_pkg::ELEM_W-1:0]    i_element,
    input  logic [sru_pkg::RANK_W-1:0]    i_rank_in,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic                          o_kind,
    output logic [sru_pkg::RANK_W-1:0]    o_rank_out,
    output logic [sru_pkg::ELEM_W-1:0]    o_element_out,
    output logic [sru_pkg::ELEM_W-1:0]    o_position,
    output logic                          o_last,
    output logic                          o_error
);

    logic [sru_pkg::CARD_W-1:0] r_card, n_card;
    logic [sru_pkg::RANK_W-1:0] r_rank_sum, n_rank_sum;
    logic [sru_pkg::CARD_W-1:0] r_element_count, n_element_count;
    logic [sru_pkg::RANK_W-1:0] r_remaining_rank, n_remaining_rank;
    logic [sru_pkg::ELEM_W-1:0] r_elem, n_elem;
    logic [sru_pkg::ELEM_W-1:0] r_p, n_p;
    logic [sru_pkg::CARD_W-1:0] r_j, n_j;

    logic                       r_out_valid, n_out_valid;
    logic                       r_kind, n_kind;
    logic [sru_pkg::RANK_W-1:0] r_rank_out, n_rank_out;
    logic [sru_pkg::ELEM_W-1:0] r_element_out, n_element_out;
    logic [sru_pkg::ELEM_W-1:0] r_position, n_position;
    logic                       r_last, n_last;
    logic                       r_error, n_error;

    logic [sru_pkg::CARD_W-1:0] w_k;
    logic [sru_pkg::CARD_W-1:0] w_count_inc;
    logic [sru_pkg::CARD_W-1:0] w_rom_n;
    logic [sru_pkg::CARD_W-1:0] w_rom_j;
    logic [sru_pkg::RANK_W-1:0] w_rom;
    logic [sru_pkg::RANK_W:0]   w_sum_wide;
    logic [sru_pkg::RANK_W-1:0] w_sum_sat;

    // card zero behaves as card one
    assign w_k         = (r_card == '0) ? sru_pkg::CARD_W'(1) : r_card;
    assign w_count_inc = r_element_count + sru_pkg::CARD_W'(1);

    always_comb begin
        unique case (i_cmd.addr_sel)
            sru_pkg::ADDR_RANK: begin
                w_rom_n = {1'b0, r_elem};
                w_rom_j = w_count_inc;
            end
            sru_pkg::ADDR_LIMIT: begin
                w_rom_n = sru_pkg::CARD_W'(sru_pkg::MAX_VARIETIES);
                w_rom_j = w_k;
            end
            sru_pkg::ADDR_SCAN: begin
                w_rom_n = {1'b0, r_p};
                w_rom_j = r_j;
            end
            default: begin
                w_rom_n = '0;
                w_rom_j = '0;
            end
        endcase
    end

    sru_binom_rom u_rom (
        .i_clk  (i_clk),
        .i_n    (w_rom_n),
        .i_j    (w_rom_j),
        .o_data (w_rom)
    );

    // saturating rank accumulation
    assign w_sum_wide = {1'b0, r_rank_sum} + {1'b0, w_rom};
    assign w_sum_sat  = w_sum_wide[sru_pkg::RANK_W] ? '1 : w_sum_wide[sru_pkg::RANK_W-1:0];

    assign o_sts.rank_done = (w_count_inc >= w_k);
    assign o_sts.in_range  = (r_remaining_rank < w_rom);
    assign o_sts.found     = (w_rom <= r_remaining_rank);
    assign o_sts.last_elem = (r_j == sru_pkg::CARD_W'(1));
    assign o_sts.slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_card           = r_card;
        n_rank_sum       = r_rank_sum;
        n_element_count  = r_element_count;
        n_remaining_rank = r_remaining_rank;
        n_elem           = r_elem;
        n_p              = r_p;
        n_j              = r_j;
        n_out_valid      = r_out_valid && i_out_stall;
        n_kind           = r_kind;
        n_rank_out       = r_rank_out;
        n_element_out    = r_element_out;
        n_position       = r_position;
        n_last           = r_last;
        n_error          = r_error;

        if (i_cfg_we) begin
            n_card = i_cfg_data;
        end
        if (i_cmd.capture) begin
            n_elem           = i_element;
            n_remaining_rank = i_rank_in;
        end
        if (i_cmd.rank_acc) begin
            n_rank_sum      = w_sum_sat;
            n_element_count = w_count_inc;
        end
        if (i_cmd.rank_emit) begin
            n_out_valid     = 1'b1;
            n_kind          = 1'b0;
            n_rank_out      = r_rank_sum;
            n_element_out   = '0;
            n_position      = '0;
            n_last          = 1'b1;
            n_error         = 1'b0;
            n_rank_sum      = '0;
            n_element_count = '0;
        end
        if (i_cmd.err_emit) begin
            n_out_valid   = 1'b1;
            n_kind        = 1'b1;
            n_rank_out    = '0;
            n_element_out = '0;
            n_position    = '0;
            n_last        = 1'b1;
            n_error       = 1'b1;
        end
        if (i_cmd.scan_init) begin
            n_p = sru_pkg::ELEM_W'(sru_pkg::MAX_VARIETIES - 1);
            n_j = w_k;
        end
        if (i_cmd.scan_step) begin
            n_p = r_p - sru_pkg::ELEM_W'(1);
        end
        if (i_cmd.elem_emit) begin
            n_out_valid      = 1'b1;
            n_kind           = 1'b1;
            n_rank_out       = '0;
            n_element_out    = r_p;
            n_position       = sru_pkg::ELEM_W'(r_j - sru_pkg::CARD_W'(1));
            n_last           = (r_j == sru_pkg::CARD_W'(1));
            n_error          = 1'b0;
            n_remaining_rank = r_remaining_rank - w_rom;
            n_j              = r_j - sru_pkg::CARD_W'(1);
            n_p              = r_p - sru_pkg::ELEM_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_card           <= sru_pkg::CARD_RESET;
            r_rank_sum       <= '0;
            r_element_count  <= '0;
            r_remaining_rank <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_card           <= n_card;
            r_rank_sum       <= n_rank_sum;
            r_element_count  <= n_element_count;
            r_remaining_rank <= n_remaining_rank;
            r_out_valid      <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_elem        <= n_elem;
        r_p           <= n_p;
        r_j           <= n_j;
        r_kind        <= n_kind;
        r_rank_out    <= n_rank_out;
        r_element_out <= n_element_out;
        r_position    <= n_position;
        r_last        <= n_last;
        r_error       <= n_error;
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_rank_out    = r_rank_out;
    assign o_element_out = r_element_out;
    assign o_position    = r_position;
    assign o_last        = r_last;
    assign o_error       = r_error;

endmodule

// ===== rtl/sru_ctrl.sv =====
module sru_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_mode,
    input  sru_pkg::t_sts  i_sts,
    output sru_pkg::t_cmd  o_cmd,
    output logic           o_in_stall
);

    sru_pkg::t_state r_state, n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.addr_sel = sru_pkg::ADDR_SCAN;

        unique case (r_state)
            sru_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_mode ? sru_pkg::S_U_LIMIT : sru_pkg::S_R_FETCH;
                end
            end
            sru_pkg::S_R_FETCH: begin
                o_cmd.addr_sel = sru_pkg::ADDR_RANK;
                n_state        = sru_pkg::S_R_ADD;
            end
            sru_pkg::S_R_ADD: begin
                o_cmd.addr_sel = sru_pkg::ADDR_RANK;
                o_cmd.rank_acc = 1'b1;
                n_state = i_sts.rank_done ? sru_pkg::S_R_EMIT : sru_pkg::S_IDLE;
            end
            sru_pkg::S_R_EMIT: begin
                if (i_sts.slot_free) begin
                    o_cmd.rank_emit = 1'b1;
                    n_state         = sru_pkg::S_IDLE;
                end
            end
            sru_pkg::S_U_LIMIT: begin
                o_cmd.addr_sel = sru_pkg::ADDR_LIMIT;
                n_state        = sru_pkg::S_U_CHECK;
            end
            sru_pkg::S_U_CHECK: begin
                o_cmd.addr_sel = sru_pkg::ADDR_LIMIT;
                if (i_sts.in_range) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = sru_pkg::S_U_FETCH;
                end else begin
                    n_state = sru_pkg::S_U_ERR;
                end
            end
            sru_pkg::S_U_ERR: begin
                if (i_sts.slot_free) begin
                    o_cmd.err_emit = 1'b1;
                    n_state        = sru_pkg::S_IDLE;
                end
            end
            sru_pkg::S_U_FETCH: begin
                n_state = sru_pkg::S_U_TEST;
            end
            sru_pkg::S_U_TEST: begin
                // rom data stays valid here since p and j hold
                if (i_sts.found) begin
                    if (i_sts.slot_free) begin
                        o_cmd.elem_emit = 1'b1;
                        n_state = i_sts.last_elem ? sru_pkg::S_IDLE : sru_pkg::S_U_FETCH;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                    n_state         = sru_pkg::S_U_FETCH;
                end
            end
            default: begin
                n_state = sru_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sru_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != sru_pkg::S_IDLE);

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import sru_pkg::*;

    // opcodes on the input beat and kinds on the result beat
    localparam logic MODE_RANK   = 1'b0;
    localparam logic MODE_UNRANK = 1'b1;
    localparam logic KIND_RANK   = 1'b0;
    localparam logic KIND_ELEM   = 1'b1;

    localparam longint unsigned RANK_MAX = (64'd1 << RANK_W) - 1;

    // covers the worst unrank candidate walk plus slack
    localparam int unsigned DRAIN_CYCLES = 2 * MAX_VARIETIES + 40;
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned NUM_PHASES   = 8;
    localparam int unsigned PHASE_ITEMS  = 8;
    localparam int unsigned MAX_GAP      = 12;

    typedef struct packed {
        logic              kind;
        logic [RANK_W-1:0] rank_out;
        logic [ELEM_W-1:0] element_out;
        logic [ELEM_W-1:0] position;
        logic              last;
        logic              error;
    } t_result_beat;

    typedef enum logic [1:0] {
        ROW_RANK,
        ROW_UNRANK,
        ROW_CARD
    } t_row_op;

    typedef struct packed {
        t_row_op           op;
        logic [ELEM_W-1:0] elem;
        logic [RANK_W-1:0] rank;
        logic [CARD_W-1:0] card;
        logic              typed;
        t_result_beat      want;
    } t_script_row;

    typedef enum logic [2:0] {
        SEQ_SUBSET,
        SEQ_UNRANK_OK,
        SEQ_UNRANK_BAD,
        SEQ_BROKEN,
        SEQ_SATURATE
    } t_seq_kind;

    localparam t_result_beat NO_BEAT    = '0;
    localparam t_result_beat ERROR_BEAT = '{KIND_ELEM, 30'd0, 5'd0, 5'd0, 1'b1, 1'b1};
    localparam int unsigned  NUM_ROWS   = 27;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_mode;
    logic [ELEM_W-1:0] i_element;
    logic [RANK_W-1:0] i_rank_in;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_kind;
    logic [RANK_W-1:0] o_rank_out;
    logic [ELEM_W-1:0] o_element_out;
    logic [ELEM_W-1:0] o_position;
    logic              o_last;
    logic              o_error;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CARD_W-1:0] i_cfg_data;

    // predictor state: card register, rank accumulator, leftover of the last unrank
    logic [CARD_W-1:0] mdl_card;
    logic [RANK_W-1:0] mdl_rank_sum;
    logic [CARD_W-1:0] mdl_elem_count;
    logic [RANK_W-1:0] mdl_leftover_rank;

    longint unsigned binom_tab [0:MAX_VARIETIES][0:63];
    t_result_beat    colex_result_q [$];
    t_script_row     script_rows [0:NUM_ROWS-1];
    int unsigned     mismatch_count;
    int unsigned     quiet_cycles;

    // per-phase idling knobs, and the request for one long receiver hold-off
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_req;

    subset_rank_unrank_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_element     (i_element),
        .i_rank_in     (i_rank_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_rank_out    (o_rank_out),
        .o_element_out (o_element_out),
        .o_position    (o_position),
        .o_last        (o_last),
        .o_error       (o_error),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // C(n, j) from the pascal table, zero outside it and for j > n
    function automatic longint unsigned binom(int unsigned n, int unsigned j);
        return (n > MAX_VARIETIES || j > 63) ? 0 : binom_tab[n][j];
    endfunction

    function automatic t_result_beat rank_beat(logic [RANK_W-1:0] r);
        t_result_beat b;
        b          = '0;
        b.kind     = KIND_RANK;
        b.rank_out = r;
        b.last     = 1'b1;
        return b;
    endfunction

    // colex rank / unrank step: queues the result beats one input beat causes
    // and returns how many it queued
    function automatic int rank_unrank_predict(logic mode, logic [ELEM_W-1:0] elem,
                                               logic [RANK_W-1:0] rank_val);
        int unsigned     k;
        int unsigned     i;
        int unsigned     p;
        int              n;
        longint unsigned sum;
        longint unsigned left;
        t_result_beat    beat;
        k = (mdl_card == 0) ? 1 : mdl_card;
        n = 0;
        if (mode == MODE_RANK) begin
            // element at position c contributes C(element, c+1), sum saturates
            sum = mdl_rank_sum + binom(elem, mdl_elem_count + 1);
            if (sum > RANK_MAX) begin
                sum = RANK_MAX;
            end
            mdl_rank_sum   = sum[RANK_W-1:0];
            mdl_elem_count = mdl_elem_count + 1'b1;
            // >= rather than == so a lowered card closes the subset at once
            if (mdl_elem_count >= k) begin
                colex_result_q.push_back(rank_beat(mdl_rank_sum));
                mdl_rank_sum   = '0;
                mdl_elem_count = '0;
                n              = 1;
            end
        end else begin
            left = rank_val;
            // C(32, k) is zero for k above 32, so every rank is out of range there
            if (left >= binom(MAX_VARIETIES, k)) begin
                colex_result_q.push_back(ERROR_BEAT);
                n = 1;
            end else begin
                // greedy search, largest position first
                for (i = k; i > 0; i--) begin
                    p = i - 1;
                    while (p < 31 && binom(p + 1, i) <= left) begin
                        p++;
                    end
                    left             = left - binom(p, i);
                    beat             = '0;
                    beat.kind        = KIND_ELEM;
                    beat.element_out = 5'(p);
                    beat.position    = 5'(i - 1);
                    beat.last        = (i == 1);
                    colex_result_q.push_back(beat);
                    n++;
                end
                mdl_leftover_rank = left[RANK_W-1:0];
            end
        end
        return n;
    endfunction

    // one input beat: optional gap, then hold until accepted; leaves at a falling edge
    task automatic send_item(input logic mode, input logic [ELEM_W-1:0] elem,
                             input logic [RANK_W-1:0] rank_val, input logic use_want,
                             input t_result_beat want);
        int unsigned gap;
        int          nb;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_element  <= elem;
        i_rank_in  <= rank_val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        nb = rank_unrank_predict(mode, elem, rank_val);
        // typed rows replace what the predictor queued for this beat
        if (use_want) begin
            repeat (nb) void'(colex_result_q.pop_back());
            colex_result_q.push_back(want);
        end
        @(negedge i_clk);
    endtask

    // card write only with the block drained and quiet
    task automatic write_card(input logic [CARD_W-1:0] value);
        i_in_valid <= 1'b0;
        while (colex_result_q.size() != 0) @(negedge i_clk);
        // a rank beat that closes nothing may still be in flight
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mdl_card = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // result side: a stall length drawn per beat, or the one long hold-off
    initial begin : result_sink
        int unsigned stall_len;
        i_out_stall <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                stall_len = HOLD_CYCLES;
                hold_req  = 1'b0;
            end else begin
                stall_len = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (stall_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // compare every accepted result beat against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (colex_result_q.size() == 0) begin
                $error("result beat with nothing expected: kind %0d rank %0d elem %0d",
                       o_kind, o_rank_out, o_element_out);
                mismatch_count++;
            end else begin
                want = colex_result_q.pop_front();
                check_field("kind", want.kind, o_kind);
                check_field("rank_out", want.rank_out, o_rank_out);
                check_field("element_out", want.element_out, o_element_out);
                check_field("position", want.position, o_position);
                check_field("last", want.last, o_last);
                check_field("error", want.error, o_error);
            end
        end
    end

    // watchdog on cycles where no channel moves a beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned       row;
        int unsigned       phase;
        int unsigned       sent;
        int unsigned       k_eff;
        int unsigned       need;
        int unsigned       v;
        int unsigned       len;
        int unsigned       draw;
        longint unsigned   lim;
        logic [CARD_W-1:0] new_card;
        t_seq_kind         pick;
        t_script_row       r;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_mode         = MODE_RANK;
        i_element      = '0;
        i_rank_in      = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = CARD_RESET;
        mismatch_count = 0;
        quiet_cycles   = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        hold_req       = 1'b0;

        mdl_card          = CARD_RESET;
        mdl_rank_sum      = '0;
        mdl_elem_count    = '0;
        mdl_leftover_rank = '0;

        for (int n = 0; n <= MAX_VARIETIES; n++) begin
            for (int j = 0; j < 64; j++) begin
                binom_tab[n][j] = (j == 0) ? 1 :
                                  (n == 0) ? 0 : binom_tab[n-1][j-1] + binom_tab[n-1][j];
            end
        end

        // directed rows; typed results are read straight off the definition
        script_rows = '{
            // card 2 out of reset: smallest and largest 2-subsets
            '{ROW_RANK,   5'd0,  30'd0,         6'd0,  1'b0, NO_BEAT},
            '{ROW_RANK,   5'd1,  30'd0,         6'd0,  1'b1, rank_beat(30'd0)},
            '{ROW_RANK,   5'd30, 30'd0,         6'd0,  1'b0, NO_BEAT},
            '{ROW_RANK,   5'd31, 30'd0,         6'd0,  1'b1, rank_beat(30'd495)},
            '{ROW_UNRANK, 5'd0,  30'd495,       6'd0,  1'b0, NO_BEAT},
            // first rank past C(32,2), and the all-ones rank
            '{ROW_UNRANK, 5'd0,  30'd496,       6'd0,  1'b1, ERROR_BEAT},
            '{ROW_UNRANK, 5'd31, 30'h3FFFFFFF,  6'd0,  1'b1, ERROR_BEAT},
            // unrank in the middle of a rank accumulation leaves it alone
            '{ROW_RANK,   5'd5,  30'd0,         6'd0,  1'b0, NO_BEAT},
            '{ROW_UNRANK, 5'd0,  30'd0,         6'd0,  1'b0, NO_BEAT},
            '{ROW_RANK,   5'd9,  30'd0,         6'd0,  1'b1, rank_beat(30'd41)},
            // card lowered with two elements pending closes on the next one
            '{ROW_CARD,   5'd0,  30'd0,         6'd3,  1'b0, NO_BEAT},
            '{ROW_RANK,   5'd2,  30'd0,         6'd0,  1'b0, NO_BEAT},
            '{ROW_RANK,   5'd4,  30'd0,         6'd0,  1'b0, NO_BEAT},
            '{ROW_CARD,   5'd0,  30'd0,         6'd1,  1'b0, NO_BEAT},
            '{ROW_RANK,   5'd7,  30'd0,         6'd0,  1'b1, rank_beat(30'd43)},
            '{ROW_RANK,   5'd31, 30'd0,         6'd0,  1'b1, rank_beat(30'd31)},
            '{ROW_UNRANK, 5'd0,  30'd31,        6'd0,  1'b0, NO_BEAT},
            '{ROW_UNRANK, 5'd0,  30'd32,        6'd0,  1'b1, ERROR_BEAT},
            // card zero behaves as card one
            '{ROW_CARD,   5'd0,  30'd0,         6'd0,  1'b0, NO_BEAT},
            '{ROW_RANK,   5'd17, 30'd0,         6'd0,  1'b1, rank_beat(30'd17)},
            '{ROW_UNRANK, 5'd0,  30'd32,        6'd0,  1'b1, ERROR_BEAT},
            // full set: 32 element beats, only rank 0 is in range
            '{ROW_CARD,   5'd0,  30'd0,         6'd32, 1'b0, NO_BEAT},
            '{ROW_UNRANK, 5'd0,  30'd0,         6'd0,  1'b0, NO_BEAT},
            '{ROW_UNRANK, 5'd0,  30'd1,         6'd0,  1'b1, ERROR_BEAT},
            // card past the table: every unrank errors, rank still accumulates
            '{ROW_CARD,   5'd0,  30'd0,         6'd40, 1'b0, NO_BEAT},
            '{ROW_UNRANK, 5'd0,  30'd0,         6'd0,  1'b1, ERROR_BEAT},
            '{ROW_RANK,   5'd31, 30'd0,         6'd0,  1'b0, NO_BEAT}
        };

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < NUM_ROWS; row++) begin
            r = script_rows[row];
            case (r.op)
                ROW_CARD:   write_card(r.card);
                ROW_RANK:   send_item(MODE_RANK, r.elem, 30'($urandom), r.typed, r.want);
                ROW_UNRANK: send_item(MODE_UNRANK, r.elem, r.rank, r.typed, r.want);
                default:    ;
            endcase
        end

        // random phases, each at its own card and idling style
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       new_card = 6'd17;
                1:       new_card = 6'd33;
                2:       new_card = 6'd63;
                3:       new_card = 6'd1;
                4:       new_card = 6'd4;
                5:       new_card = 6'd32;
                default: new_card = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(1, 6))
                                                               : 6'($urandom_range(0, 63));
            endcase
            write_card(new_card);
            tx_idle_on = (phase != 3) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (phase != 3) && ($urandom_range(0, 3) != 0);
            k_eff      = (new_card == 0) ? 1 : new_card;
            lim        = binom(MAX_VARIETIES, k_eff);
            sent       = 0;

            // back-pressure: receiver stops for a long stretch while beats keep coming
            if (phase == 4) begin
                tx_idle_on = 1'b0;
                hold_req   = 1'b1;
                repeat (10) begin
                    send_item(MODE_UNRANK, 5'($urandom), 30'($urandom_range(0, 32'(lim - 1))),
                              1'b0, NO_BEAT);
                    sent++;
                end
            end

            while (sent < PHASE_ITEMS) begin
                draw = $urandom_range(0, 19);
                if (phase == 0 && sent == 0) begin
                    pick = SEQ_SATURATE;
                end else if (draw <= 10) begin
                    pick = SEQ_SUBSET;
                end else if (draw <= 15) begin
                    pick = SEQ_UNRANK_OK;
                end else if (draw <= 17) begin
                    pick = SEQ_UNRANK_BAD;
                end else begin
                    pick = SEQ_BROKEN;
                end

                case (pick)
                    SEQ_SUBSET: begin
                        if (k_eff <= MAX_VARIETIES) begin
                            // ascending k-subset by selection sampling
                            need = k_eff;
                            for (v = 0; v < MAX_VARIETIES && need > 0; v++) begin
                                if ($urandom_range(1, MAX_VARIETIES - v) <= need) begin
                                    send_item(MODE_RANK, 5'(v), 30'($urandom), 1'b0, NO_BEAT);
                                    need--;
                                    sent++;
                                end
                            end
                        end else begin
                            // more elements than values: non-decreasing run
                            len = (k_eff > 40) ? $urandom_range(1, 8) : k_eff;
                            v   = $urandom_range(0, 3);
                            repeat (len) begin
                                send_item(MODE_RANK, 5'(v), 30'($urandom), 1'b0, NO_BEAT);
                                sent++;
                                if (v < 31 && $urandom_range(0, 1) == 1) begin
                                    v++;
                                end
                            end
                        end
                    end
                    SEQ_UNRANK_OK: begin
                        send_item(MODE_UNRANK, 5'($urandom),
                                  (lim == 0) ? 30'($urandom)
                                             : 30'($urandom_range(0, 32'(lim - 1))),
                                  1'b0, NO_BEAT);
                        sent++;
                    end
                    SEQ_UNRANK_BAD: begin
                        send_item(MODE_UNRANK, 5'($urandom),
                                  ($urandom_range(0, 1) == 1) ? 30'($urandom)
                                                               : 30'(lim + $urandom_range(0, 3)),
                                  1'b0, NO_BEAT);
                        sent++;
                    end
                    SEQ_SATURATE: begin
                        // repeated top element pushes the sum past 30 bits
                        repeat (k_eff) begin
                            send_item(MODE_RANK, 5'd31, 30'($urandom), 1'b0, NO_BEAT);
                            sent++;
                        end
                    end
                    default: begin
                        repeat ($urandom_range(1, 3)) begin
                            send_item(MODE_RANK, 5'($urandom), 30'($urandom), 1'b0, NO_BEAT);
                            sent++;
                        end
                    end
                endcase
            end
        end

        i_in_valid <= 1'b0;
        while (colex_result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
